[rtl/alsi_pkg.sv]
// Shared types and constants for the sorted array list block.
// No dependencies; used by alsi_cell and array_list_sorted_insert_remove_core.
`default_nettype none

package alsi_pkg;

  // Request operation codes.
  localparam logic [2:0] FN_INS_FRONT = 3'd0;
  localparam logic [2:0] FN_INS_ORD   = 3'd1;
  localparam logic [2:0] FN_INS_BACK  = 3'd2;
  localparam logic [2:0] FN_REM_FRONT = 3'd3;
  localparam logic [2:0] FN_REM_VALUE = 3'd4;
  localparam logic [2:0] FN_REM_BACK  = 3'd5;

  // What a cell does at the commit cycle.
  localparam logic [1:0] OP_NOP = 2'd0;
  localparam logic [1:0] OP_INS = 2'd1;
  localparam logic [1:0] OP_REM = 2'd2;

  // How a cell holding the search token decides whether the token moves on.
  localparam logic [1:0] MD_NONE = 2'd0;  // never moves on
  localparam logic [1:0] MD_ALL  = 2'd1;  // always moves on
  localparam logic [1:0] MD_LT   = 2'd2;  // moves on while entry < value (signed)
  localparam logic [1:0] MD_NE   = 2'd3;  // moves on while entry != value

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic       clear;  // put the token back on the first cell
    logic       step;   // token moves one cell up
    logic [1:0] mode;   // token move rule
    logic [1:0] op;     // update applied at commit
    value_t     value;  // request value
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/alsi_cell.sv]
// One cell of the list chain: holds one entry plus the search token and passed flag.
// Depends on alsi_pkg.
`default_nettype none

module alsi_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  alsi_pkg::cell_ctl_t ctl_i,
  input  wire                 tok_seed_i,
  input  wire                 tok_left_i,
  input  alsi_pkg::value_t    val_left_i,
  input  alsi_pkg::value_t    val_right_i,
  output logic                tok_o,
  output logic                hit_o,
  output alsi_pkg::value_t    val_o
);

  logic             token_r;
  logic             passed_r;
  alsi_pkg::value_t value_r;
  logic             cond;

  always_comb begin
    case (ctl_i.mode)
      alsi_pkg::MD_NONE: cond = 1'b0;
      alsi_pkg::MD_ALL:  cond = 1'b1;
      alsi_pkg::MD_LT:   cond = (value_r < ctl_i.value);
      alsi_pkg::MD_NE:   cond = (value_r != ctl_i.value);
      default:           cond = 1'b0;
    endcase
  end

  assign hit_o = token_r & cond;
  assign tok_o = token_r;
  assign val_o = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_r  <= 1'b0;
      passed_r <= 1'b0;
    end else if (ctl_i.clear) begin
      token_r  <= tok_seed_i;
      passed_r <= 1'b0;
    end else if (ctl_i.step) begin
      token_r  <= tok_left_i;
      passed_r <= passed_r | token_r;
    end
  end

  // Cells in front of the target position keep their entry; the rest shift.
  always_ff @(posedge clk) begin
    if (!passed_r) begin
      if (ctl_i.op == alsi_pkg::OP_INS) begin
        value_r <= token_r ? ctl_i.value : val_left_i;
      end else if (ctl_i.op == alsi_pkg::OP_REM) begin
        value_r <= val_right_i;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/array_list_sorted_insert_remove_core.sv]
// Top level of the bounded sorted array list: sequencer, entry count and cell chain.
// Depends on alsi_pkg and alsi_cell.
//
//  Channel  | Ports                                       | Handshake
//  ---------+---------------------------------------------+-----------------------------
//  request  | in_func, in_item_value                      | taken when start & !busy
//  result   | out_ok, out_entry_count, out_is_full,       | out_valid high for one cycle
//           | out_is_empty                                |
//
// An item passes from acceptance through the scan state, where the search token walks
// the cell chain one cell per cycle and stops at position p (0 to CAPACITY), then the
// commit state. A request that fails at once (full, empty, bad code) skips the scan.
// busy stays high from acceptance until the result is shown, so one item is in work
// at a time. Reset (rst_n low, synchronous) empties the list; entry values are not
// cleared since only entries below the count are ever read. The receiver cannot
// stall: each result is on the out_ ports for exactly one cycle.
`default_nettype none

module array_list_sorted_insert_remove_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire  [2:0]        in_func,
  input  wire signed [31:0] in_item_value,
  output logic              out_valid,
  output logic              out_ok,
  output logic [4:0]        out_entry_count,
  output logic              out_is_full,
  output logic              out_is_empty
);

  // Count holds 0 to CAPACITY inclusive.
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic [CW-1:0]       limit_r, limit_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic                is_ins_r, is_ins_nxt;
  logic                ok_r, ok_nxt;
  alsi_pkg::value_t    value_r;

  logic                out_valid_r, out_ok_r, out_full_r, out_empty_r;
  logic [CW-1:0]       out_count_r;

  alsi_pkg::cell_ctl_t ctl;
  logic [CAPACITY-1:0] tok;
  logic [CAPACITY-1:0] hit;
  alsi_pkg::value_t    val [CAPACITY];

  logic                full, empty, adv, req_ins, req_rem;

  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);

  // The token moves on while it is below the limit and its cell says so.
  assign adv = (ptr_r != limit_r) && (|hit);

  always_comb begin
    req_ins = 1'b0;
    req_rem = 1'b0;
    case (in_func)
      alsi_pkg::FN_INS_FRONT, alsi_pkg::FN_INS_ORD, alsi_pkg::FN_INS_BACK: req_ins = 1'b1;
      alsi_pkg::FN_REM_FRONT, alsi_pkg::FN_REM_VALUE, alsi_pkg::FN_REM_BACK: req_rem = 1'b1;
      default: ;
    endcase
  end

  // Sequencer: on acceptance it picks the token rule and limit; in the scan state the
  // token walks until it stops; in the commit state the cells shift and the count moves.
  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    limit_nxt  = limit_r;
    mode_nxt   = mode_r;
    is_ins_nxt = is_ins_r;
    ok_nxt     = ok_r;
    count_nxt  = count_r;

    ctl.clear = 1'b0;
    ctl.step  = 1'b0;
    ctl.mode  = mode_r;
    ctl.op    = alsi_pkg::OP_NOP;
    ctl.value = value_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.clear  = 1'b1;
          ptr_nxt    = '0;
          limit_nxt  = count_r;
          is_ins_nxt = req_ins;
          ok_nxt     = 1'b0;
          case (in_func)
            alsi_pkg::FN_INS_ORD:   mode_nxt = alsi_pkg::MD_LT;
            alsi_pkg::FN_INS_BACK:  mode_nxt = alsi_pkg::MD_ALL;
            alsi_pkg::FN_REM_VALUE: mode_nxt = alsi_pkg::MD_NE;
            alsi_pkg::FN_REM_BACK: begin
              mode_nxt  = alsi_pkg::MD_ALL;
              limit_nxt = count_r - CW'(1);
            end
            default:                mode_nxt = alsi_pkg::MD_NONE;
          endcase
          // Full, empty or an unknown code fail without a scan.
          if ((req_ins && !full) || (req_rem && !empty)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        if (adv) begin
          ctl.step = 1'b1;
          ptr_nxt  = ptr_r + CW'(1);
        end else begin
          // An insert always finds its slot; a remove fails if the token ran off the end.
          ok_nxt    = is_ins_r || (ptr_r != count_r);
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (ok_r) begin
          if (is_ins_r) begin
            ctl.op    = alsi_pkg::OP_INS;
            count_nxt = count_r + CW'(1);
          end else begin
            ctl.op    = alsi_pkg::OP_REM;
            count_nxt = count_r - CW'(1);
          end
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      limit_r     <= '0;
      mode_r      <= alsi_pkg::MD_NONE;
      is_ins_r    <= 1'b0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      limit_r     <= limit_nxt;
      mode_r      <= mode_nxt;
      is_ins_r    <= is_ins_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= (state_r == ST_COMMIT);
    end
  end

  // Request value and result fields carry no reset.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      value_r <= in_item_value;
    end
    if (state_r == ST_COMMIT) begin
      out_ok_r    <= ok_r;
      out_count_r <= count_nxt;
      out_full_r  <= (count_nxt == CW'(CAPACITY));
      out_empty_r <= (count_nxt == '0);
    end
  end

  // The cell chain. Cell 0 takes the token on clear; each cell hands its token and its
  // entry to the next one up, and its entry to the one below.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic             seed;
    logic             tok_left;
    alsi_pkg::value_t val_left;
    alsi_pkg::value_t val_right;

    if (k == 0) begin : g_first
      assign seed     = 1'b1;
      assign tok_left = 1'b0;
      assign val_left = '0;
    end else begin : g_mid
      assign seed     = 1'b0;
      assign tok_left = tok[k-1];
      assign val_left = val[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign val_right = '0;
    end else begin : g_inner
      assign val_right = val[k+1];
    end

    alsi_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl_i       (ctl),
      .tok_seed_i  (seed),
      .tok_left_i  (tok_left),
      .val_left_i  (val_left),
      .val_right_i (val_right),
      .tok_o       (tok[k]),
      .hit_o       (hit[k]),
      .val_o       (val[k])
    );
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_entry_count = 5'(out_count_r);
  assign out_is_full     = out_full_r;
  assign out_is_empty    = out_empty_r;

endmodule

`default_nettype wire
